@@ src/uart_idle_gap_frame_assembler_top_defines.svh @@
// Assertion macros shared by the checker of the idle-gap frame assembler.
`ifndef UART_IDLE_GAP_FRAME_ASSEMBLER_TOP_DEFINES_SVH
`define UART_IDLE_GAP_FRAME_ASSEMBLER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UGFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UGFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ugfa_pkg.sv @@
// Package of the idle-gap frame assembler: sizes, codes, state type and helpers.
package ugfa_pkg;

  localparam int CHANNELS  = 2;
  localparam int BUF_BYTES = 32;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(BUF_BYTES + 1);
  localparam int ADDR_W   = (CHANNELS * BUF_BYTES > 1) ? $clog2(CHANNELS * BUF_BYTES) : 1;
  localparam int BYTE_W   = 8;
  localparam int TICK_W   = 32;
  localparam int GAP_W    = 16;
  localparam int LEN_W    = 6;

  localparam int IN_TDATA_W  = BYTE_W + TICK_W;
  localparam int IN_TUSER_W  = 1 + CH_W;
  localparam int LEN_LSB     = BYTE_W;
  localparam int OUT_TDATA_W = ((BYTE_W + LEN_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP    = CFG_IDX_W'(1);

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(3);

  localparam logic OP_RX    = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // Byte slot of a channel's buffer inside the shared frame store.
  function automatic logic [ADDR_W-1:0] frame_addr(input logic [CH_W-1:0] ch,
                                                   input logic [CNT_W-1:0] idx);
    frame_addr = ADDR_W'(int'(ch) * BUF_BYTES + int'(idx));
  endfunction

endpackage

@@ src/ugfa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module ugfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/uart_idle_gap_frame_assembler_top.sv @@
// Top level of the idle-gap frame assembler: channel buffers, idle scan and frame drain.
//
//   channel  direction  tdata / data                     tuser / index       tlast
//   in_      slave      rx_byte, now_tick                operation, channel  -
//   out_     master     frame_byte, frame_length         frame_channel       last_of_frame
//   cfg_     slave      register value                   register index      -
//
// For a receive word, its byte is written into the frame store and the
// channel's fill count and last-receive tick are updated in the same cycle.
// A check word is accepted, the channels are scanned in turn, and each closed frame is
// drained one byte per cycle with out_tready held high; the single read
// port of the frame store sets that one-byte-per-cycle drain.
// Output back-pressure stalls the drain, the read address is held and the RAM keeps
// presenting the same byte. Reset clears the state machine, fill counts, ticks and the
// registers; the frame store needs no clearing since fill counts guard every read.
module uart_idle_gap_frame_assembler_top
  import ugfa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input word.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // rx_byte [7:0], now_tick [39:8]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // operation [0], channel above it
  // Result word.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // frame_byte [7:0], frame_length [13:8], zero pad
  output logic [CH_W-1:0]        out_tuser,  // frame_channel
  output logic                   out_tlast,  // last_of_frame
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Input fields.
  logic              in_op;
  logic [CH_W-1:0]   in_ch;
  logic [BYTE_W-1:0] in_byte;
  logic [TICK_W-1:0] in_now;
  logic              in_acc;

  assign in_op   = in_tuser[0];
  assign in_ch   = in_tuser[CH_W:1];
  assign in_byte = in_tdata[BYTE_W-1:0];
  assign in_now  = in_tdata[BYTE_W +: TICK_W];
  assign in_acc  = in_tvalid && in_tready;

  // Control and per-channel state.
  state_t            state_r, state_nxt;
  logic [CH_W-1:0]   scan_ch_r, scan_ch_nxt;
  logic [TICK_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  next_idx_r, next_idx_nxt;
  logic [CNT_W-1:0]  shown_idx_r, shown_idx_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [CNT_W-1:0]  fill_r [CHANNELS];
  logic [TICK_W-1:0] tick_r [CHANNELS];
  logic [CHANNELS-1:0] mask_r;
  logic [GAP_W-1:0]  gap_r;

  // One channel is looked at per cycle: the receiving one while idle, else the scanned one.
  logic [CH_W-1:0]   sel_ch;
  logic [CNT_W-1:0]  sel_fill;
  logic [TICK_W-1:0] sel_tick;
  logic [TICK_W-1:0] idle_time;
  logic              close_frame;
  logic              last_ch;
  logic              drain_adv;

  logic              fill_we;
  logic [CNT_W-1:0]  fill_wval;
  logic              tick_we;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign sel_ch    = (state_r == ST_IDLE) ? in_ch : scan_ch_r;
  assign sel_fill  = fill_r[sel_ch];
  assign sel_tick  = tick_r[sel_ch];
  assign idle_time = now_r - sel_tick;
  assign close_frame = mask_r[scan_ch_r] && (sel_fill != '0) &&
                       (idle_time >= TICK_W'(gap_r));
  assign last_ch   = (scan_ch_r == CH_W'(CHANNELS - 1));
  assign drain_adv = !out_vld_r || out_tready;
  assign ram_waddr = frame_addr(in_ch, sel_fill);

  always_comb begin
    state_nxt     = state_r;
    scan_ch_nxt   = scan_ch_r;
    now_nxt       = now_r;
    len_nxt       = len_r;
    next_idx_nxt  = next_idx_r;
    shown_idx_nxt = shown_idx_r;
    out_vld_nxt   = out_vld_r;
    fill_we       = 1'b0;
    fill_wval     = '0;
    tick_we       = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = frame_addr(scan_ch_r, shown_idx_r);
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_CHECK) begin
            now_nxt     = in_now;
            scan_ch_nxt = '0;
            state_nxt   = ST_SCAN;
          end else if (int'(in_ch) < CHANNELS) begin
            tick_we = 1'b1;
            // A byte for a full buffer is dropped; the tick still moves.
            if (int'(sel_fill) < BUF_BYTES) begin
              ram_we    = 1'b1;
              fill_we   = 1'b1;
              fill_wval = sel_fill + CNT_W'(1);
            end
          end
        end
      end
      ST_SCAN: begin
        if (close_frame) begin
          len_nxt      = sel_fill;
          next_idx_nxt = '0;
          out_vld_nxt  = 1'b0;
          state_nxt    = ST_DRAIN;
        end else if (last_ch) begin
          state_nxt = ST_IDLE;
        end else begin
          scan_ch_nxt = scan_ch_r + CH_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_adv) begin
          if (next_idx_r < len_r) begin
            ram_raddr     = frame_addr(scan_ch_r, next_idx_r);
            out_vld_nxt   = 1'b1;
            shown_idx_nxt = next_idx_r;
            next_idx_nxt  = next_idx_r + CNT_W'(1);
          end else begin
            // Whole frame delivered: empty the buffer and move on.
            out_vld_nxt = 1'b0;
            fill_we     = 1'b1;
            fill_wval   = '0;
            if (last_ch) begin
              state_nxt = ST_IDLE;
            end else begin
              scan_ch_nxt = scan_ch_r + CH_W'(1);
              state_nxt   = ST_SCAN;
            end
          end
        end
      end
      default: begin
        state_nxt   = ST_IDLE;
        out_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      mask_r    <= '0;
      gap_r     <= GAP_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        fill_r[c] <= '0;
        tick_r[c] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (fill_we) begin
        fill_r[sel_ch] <= fill_wval;
      end
      if (tick_we) begin
        tick_r[sel_ch] <= in_now;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENABLE_MASK: mask_r <= cfg_data[CHANNELS-1:0];
          CFG_IDLE_GAP:    gap_r  <= cfg_data[GAP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_ch_r   <= scan_ch_nxt;
    now_r       <= now_nxt;
    len_r       <= len_nxt;
    next_idx_r  <= next_idx_nxt;
    shown_idx_r <= shown_idx_nxt;
  end

  ugfa_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CHANNELS * BUF_BYTES)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_byte),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - BYTE_W - LEN_W)'(0), LEN_W'(len_r), ram_rdata};
  assign out_tuser  = scan_ch_r;
  assign out_tlast  = (shown_idx_r == len_r - CNT_W'(1));

endmodule

@@ src/ugfa_checker.sv @@
// Port-level checker of the idle-gap frame assembler, bound to the top level.
`include "uart_idle_gap_frame_assembler_top_defines.svh"

module ugfa_checker
  import ugfa_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [CH_W-1:0]        out_tuser,
  input logic                   out_tlast
);

  // A stalled result word keeps its contents.
  `UGFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result word changed")

  // No input is taken while a frame is being delivered.
  `UGFA_ASSERT_NOW(a_no_accept_in_drain, clk, rst_n, out_tvalid, !in_tready, "input ready during frame drain")

  // A received byte never produces a result in the following cycle.
  `UGFA_ASSERT_NEXT(a_rx_silent, clk, rst_n, in_tvalid && in_tready && (in_tuser[0] == OP_RX), !out_tvalid, "result after a received byte")

  // A frame continues without a gap until its last byte.
  `UGFA_ASSERT_NEXT(a_frame_continues, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid, "frame interrupted before its last byte")

  // Every delivered byte belongs to a frame of at least one byte.
  `UGFA_ASSERT_NOW(a_len_nonzero, clk, rst_n, out_tvalid, out_tdata[LEN_LSB +: LEN_W] != '0, "frame length of zero")

endmodule

bind uart_idle_gap_frame_assembler_top ugfa_checker u_ugfa_checker (.*);
